// ===== rtl/stq_pkg.sv =====
// Shared types and constants for the sorted timeout queue.
// No dependencies; imported by stq_ram users and the top level.
package stq_pkg;

   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned N_W = 5;   // holds 0..MAX_RESULTS

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ACCEPTED = 2'd0,
      KIND_REJECTED = 2'd1,
      KIND_EXPIRED  = 2'd2,
      KIND_IDLE     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_WR,
      ST_EXP_RD,
      ST_EXP_CMP,
      ST_EXP_FIN
   } state_type;

   typedef struct packed {
      logic [31:0] deadline;
      logic [15:0] handle;
   } entry_type;

   // Deadline a is not later than b, modulo 2^32.
   function automatic logic not_later(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = b - a;
      return ~diff[31];
   endfunction

endpackage

// ===== rtl/sorted_timeout_queue.sv =====
// Sorted timeout queue: top level with sequencer, pointers and time counter.
// Depends on stq_pkg and stq_ram.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -----------------------------
//  request   req_command, req_timeout, req_event_id  start && !busy accepts
//  response  rsp_kind, rsp_expired_id, rsp_pending,  rsp_strobe, one cycle each,
//            rsp_last                                 no back-pressure
//
// An add walks from the back toward the front, a read and a compare state per
// entry; each later entry moves up one slot (at most QUEUE_DEPTH-1 of them),
// and the walk ends at the front or at an entry that is not later. A rejected add
// or an empty tick answers next cycle. A non-empty tick pops the head entry
// while it is due, up to the pop limit or the last entry, where ST_EXP_FIN
// sends the final one; each expired transaction is held until the next compare
// gives its last bit. The entry RAM has a single read port with a registered read.
// Reset (synchronous) empties the queue and zeroes the time counter; the
// RAM contents are left as they are and only entries below the count are read.
// The receiver cannot stall; busy is already low when the last response is out.
module sorted_timeout_queue #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_command,
   input  logic [23:0]            req_timeout,
   input  logic [15:0]            req_event_id,
   output logic                   rsp_strobe,
   output stq_pkg::kind_type      rsp_kind,
   output logic [15:0]            rsp_expired_id,
   output logic [4:0]             rsp_pending,
   output logic                   rsp_last
);
   import stq_pkg::*;

   localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned EW = $bits(entry_type);
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
   localparam logic [N_W-1:0] N_LAST = N_W'(MAX_RESULTS - 1);

   // control state
   state_type      state_ff, state_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [31:0]    now_ff, now_in;
   logic [AW-1:0]  walk_ff, walk_in;     // free logical slot during insert
   logic [N_W-1:0] n_ff, n_in;           // entries popped this tick
   logic           strobe_ff, strobe_in;

   // payload
   logic [31:0]    dl_ff, dl_in;
   logic [15:0]    id_ff, id_in;
   logic [15:0]    held_id_ff, held_id_in;   // expired transaction waiting for its last bit
   logic [CW-1:0]  held_pend_ff, held_pend_in;
   kind_type       kind_ff, kind_in;
   logic [15:0]    rid_ff, rid_in;
   logic [4:0]     pend_ff, pend_in;
   logic           last_ff, last_in;

   // RAM port
   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   entry_type      wr_entry, rd_entry;
   logic [EW-1:0]  rd_raw;

   logic           accept;
   logic           full;
   logic           later;
   logic           due;
   logic           more;

   // logical queue position to physical RAM slot
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, head} + {1'b0, off};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign full     = (cnt_ff == FULL_CNT);
   assign rd_entry = entry_type'(rd_raw);
   assign later    = !not_later(rd_entry.deadline, dl_ff);
   assign due      = not_later(rd_entry.deadline, now_ff);
   // another pop allowed after this one
   assign more     = (n_ff != N_LAST) && (cnt_ff != CW'(1));

   stq_ram #(
      .WIDTH(EW),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(EW'(wr_entry)),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_ADD) begin
                  if (full) begin
                     state_in = ST_IDLE;
                  end else if (cnt_ff == '0) begin
                     state_in = ST_INS_WR;
                  end else begin
                     state_in = ST_INS_RD;
                  end
               end else if (cnt_ff != '0) begin
                  state_in = ST_EXP_RD;
               end
            end
         end
         ST_INS_RD:  state_in = ST_INS_CMP;
         ST_INS_CMP: begin
            if (later && (walk_ff != AW'(1))) begin
               state_in = ST_INS_RD;
            end else begin
               state_in = ST_INS_WR;
            end
         end
         ST_INS_WR:  state_in = ST_IDLE;
         ST_EXP_RD:  state_in = ST_EXP_CMP;
         ST_EXP_CMP: begin
            if (due) begin
               state_in = more ? ST_EXP_RD : ST_EXP_FIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EXP_FIN: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      now_in       = now_ff;
      walk_in      = walk_ff;
      n_in         = n_ff;
      dl_in        = dl_ff;
      id_in        = id_ff;
      held_id_in   = held_id_ff;
      held_pend_in = held_pend_ff;
      strobe_in    = 1'b0;
      kind_in      = kind_ff;
      rid_in       = rid_ff;
      pend_in      = pend_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;
      wr_addr      = phys(head_ff, walk_ff);
      wr_entry     = rd_entry;
      rd_addr      = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in = '0;
               if (req_command == CMD_ADD) begin
                  dl_in   = now_ff + {8'd0, req_timeout};
                  id_in   = req_event_id;
                  walk_in = cnt_ff[AW-1:0];
                  if (full) begin
                     strobe_in = 1'b1;
                     kind_in   = KIND_REJECTED;
                     rid_in    = req_event_id;
                     pend_in   = 5'(cnt_ff);
                     last_in   = 1'b1;
                  end
               end else begin
                  now_in = now_ff + 32'd1;
                  if (cnt_ff == '0) begin
                     strobe_in = 1'b1;
                     kind_in   = KIND_IDLE;
                     rid_in    = '0;
                     pend_in   = '0;
                     last_in   = 1'b1;
                  end
               end
            end
         end
         ST_INS_RD: begin
            rd_addr = phys(head_ff, walk_ff - AW'(1));
         end
         ST_INS_CMP: begin
            // entry below the free slot is later: move it up one
            if (later) begin
               wr_en   = 1'b1;
               walk_in = walk_ff - AW'(1);
            end
         end
         ST_INS_WR: begin
            wr_en     = 1'b1;
            wr_entry  = '{deadline: dl_ff, handle: id_ff};
            cnt_in    = cnt_ff + CW'(1);
            strobe_in = 1'b1;
            kind_in   = KIND_ACCEPTED;
            rid_in    = id_ff;
            pend_in   = 5'(cnt_ff + CW'(1));
            last_in   = 1'b1;
         end
         ST_EXP_RD: begin
            rd_addr = head_ff;
         end
         ST_EXP_CMP: begin
            if (due) begin
               // the previous pop is not the last one: release it
               if (n_ff != '0) begin
                  strobe_in = 1'b1;
                  kind_in   = KIND_EXPIRED;
                  rid_in    = held_id_ff;
                  pend_in   = 5'(held_pend_ff);
                  last_in   = 1'b0;
               end
               held_id_in   = rd_entry.handle;
               held_pend_in = cnt_ff - CW'(1);
               cnt_in       = cnt_ff - CW'(1);
               head_in      = (head_ff == LAST_IDX) ? '0 : head_ff + AW'(1);
               n_in         = n_ff + N_W'(1);
            end else begin
               strobe_in = 1'b1;
               last_in   = 1'b1;
               if (n_ff != '0) begin
                  kind_in = KIND_EXPIRED;
                  rid_in  = held_id_ff;
                  pend_in = 5'(held_pend_ff);
               end else begin
                  kind_in = KIND_IDLE;
                  rid_in  = '0;
                  pend_in = 5'(cnt_ff);
               end
            end
         end
         ST_EXP_FIN: begin
            strobe_in = 1'b1;
            kind_in   = KIND_EXPIRED;
            rid_in    = held_id_ff;
            pend_in   = 5'(held_pend_ff);
            last_in   = 1'b1;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         cnt_ff    <= '0;
         now_ff    <= '0;
         walk_ff   <= '0;
         n_ff      <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         cnt_ff    <= cnt_in;
         now_ff    <= now_in;
         walk_ff   <= walk_in;
         n_ff      <= n_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff        <= dl_in;
      id_ff        <= id_in;
      held_id_ff   <= held_id_in;
      held_pend_ff <= held_pend_in;
      kind_ff      <= kind_in;
      rid_ff       <= rid_in;
      pend_ff      <= pend_in;
      last_ff      <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_expired_id = rid_ff;
   assign rsp_pending    = pend_ff;
   assign rsp_last       = last_ff;

   // occupancy never passes the queue depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("entry count above queue depth");

   // a tick on an empty queue answers at once with a single idle transaction
   a_empty_tick: assert property (@(posedge clock) disable iff (reset)
      accept && (req_command == CMD_TICK) && (cnt_ff == '0)
      |=> rsp_strobe && rsp_last && (rsp_kind == KIND_IDLE) && !busy)
      else $error("empty tick did not answer");

   // responses only follow an accepted request or sequencer activity
   a_strobe_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || start))
      else $error("response without a request");

   // a pop never happens past the per-tick limit
   a_pop_limit: assert property (@(posedge clock) disable iff (reset)
      n_ff <= N_W'(MAX_RESULTS))
      else $error("too many pops on one tick");

endmodule

// ===== rtl/stq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No package dependencies.
module stq_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
